@@ sv/fis_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame interval statistics package
// Widths, reset values, register and event codes, and the control store of
// the sequencer that runs each event through the shared datapath.
// ----------------------------------------------------------------------------
package fis_pkg;

    localparam int TS_W         = 48;
    localparam int IV_W         = 20;
    localparam int WEIGHT_W     = 8;
    localparam int AVG_W        = 28;
    localparam int FPS_W        = 24;
    localparam int FPS_NUM_W    = 28;
    localparam int MODE_W       = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int MUL_A_W      = 28;
    localparam int MUL_B_W      = 9;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 184;
    localparam int OUT_PAD_W    = 3;
    localparam int STEP_W       = 4;

    localparam int DEF_WINDOW_DEPTH = 16;

    localparam logic [IV_W-1:0]      RST_MAX_IV  = 20'd100000;
    localparam logic [WEIGHT_W-1:0]  RST_WEIGHT  = 8'd51;
    localparam logic [IV_W-1:0]      RST_INIT_IV = 20'd16666;
    localparam logic [MUL_B_W-1:0]   WEIGHT_ONE  = 9'd256;
    localparam logic [FPS_NUM_W-1:0] FPS_NUM     = 28'd256000000;
    localparam logic [FPS_W-1:0]     FPS_MAX     = 24'hFFFFFF;
    localparam logic [PROD_W:0]      ROUND_HALF  = 38'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_IV = 2'd2;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FRAME = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSE = 2'd2;

    typedef enum logic [STEP_W-1:0] {
        STEP_IDLE      = 4'd0,
        STEP_DISPATCH  = 4'd1,
        STEP_START     = 4'd2,
        STEP_SUM_FILL  = 4'd3,
        STEP_PAUSE     = 4'd4,
        STEP_INTERVAL  = 4'd5,
        STEP_RING      = 4'd6,
        STEP_AVERAGE   = 4'd7,
        STEP_MEAN      = 4'd8,
        STEP_DIV_FPS   = 4'd9,
        STEP_WAIT_FPS  = 4'd10,
        STEP_SET_FPS   = 4'd11,
        STEP_OUTPUT    = 4'd12
    } step_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_START,
        OP_SUM_FILL,
        OP_PAUSE,
        OP_INTERVAL,
        OP_RING,
        OP_AVERAGE,
        OP_MEAN,
        OP_DIV_FPS,
        OP_SET_FPS,
        OP_OUTPUT
    } op_t;

    typedef enum logic [2:0] {
        COND_JUMP,
        COND_WAIT_IN,
        COND_MODE,
        COND_PAUSED,
        COND_DIV_BUSY,
        COND_WAIT_OUT
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    function automatic ctrl_t fis_rom(input step_t step);
        ctrl_t c;
        case (step)
            STEP_IDLE:      c = '{OP_ACCEPT,   COND_WAIT_IN,  STEP_DISPATCH};
            STEP_DISPATCH:  c = '{OP_NONE,     COND_MODE,     STEP_IDLE};
            STEP_START:     c = '{OP_START,    COND_JUMP,     STEP_SUM_FILL};
            STEP_SUM_FILL:  c = '{OP_SUM_FILL, COND_JUMP,     STEP_MEAN};
            STEP_PAUSE:     c = '{OP_PAUSE,    COND_JUMP,     STEP_MEAN};
            STEP_INTERVAL:  c = '{OP_INTERVAL, COND_PAUSED,   STEP_MEAN};
            STEP_RING:      c = '{OP_RING,     COND_JUMP,     STEP_AVERAGE};
            STEP_AVERAGE:   c = '{OP_AVERAGE,  COND_JUMP,     STEP_MEAN};
            STEP_MEAN:      c = '{OP_MEAN,     COND_JUMP,     STEP_DIV_FPS};
            STEP_DIV_FPS:   c = '{OP_DIV_FPS,  COND_JUMP,     STEP_WAIT_FPS};
            STEP_WAIT_FPS:  c = '{OP_NONE,     COND_DIV_BUSY, STEP_SET_FPS};
            STEP_SET_FPS:   c = '{OP_SET_FPS,  COND_JUMP,     STEP_OUTPUT};
            STEP_OUTPUT:    c = '{OP_OUTPUT,   COND_WAIT_OUT, STEP_IDLE};
            default:        c = '{OP_NONE,     COND_JUMP,     STEP_IDLE};
        endcase
        return c;
    endfunction

    function automatic step_t mode_target(input logic [MODE_W-1:0] mode);
        step_t s;
        case (mode)
            MODE_START: s = STEP_START;
            MODE_FRAME: s = STEP_INTERVAL;
            MODE_PAUSE: s = STEP_PAUSE;
            default:    s = STEP_MEAN;
        endcase
        return s;
    endfunction

endpackage

@@ sv/frame_interval_statistics_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame interval statistics
// Interval, smoothed interval, window mean, frame rate and counters over
// microsecond event timestamps, run by a microcoded sequencer. The window
// depth is a power of two, so the window mean is a shift of the window sum.
// ----------------------------------------------------------------------------
// Sequence: an event is taken in the idle step and dispatched on its mode;
// unused events go straight to the window mean, others run their mode's steps
// first, then the bit-serial frame-rate divide and the output step follow. A
// held result stalls the steps. Events are taken one at a time.
// Reset: statistics but the window mean and frame rate take initial values at
// once; ring entries not written since reset or the last start event read as fill.
// ----------------------------------------------------------------------------
module frame_interval_statistics_top
    import fis_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [IV_W-1:0]        cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // timestamp_us [47:0], pause_value [48], zero [55:49]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // mode [1:0]
    input  logic [MODE_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // interval_us [19:0], smoothed_interval_us [39:20], window_mean_us [59:40],
    // frames_per_second_q8 [83:60], frame_count [131:84], elapsed_us [179:132],
    // is_paused [180], zero [183:181]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W = IV_W + PTR_W;
    localparam int NUM_W = FPS_NUM_W;
    localparam logic [SUM_W-1:0]   RESET_SUM = SUM_W'(WINDOW_DEPTH * int'(RST_INIT_IV));
    localparam logic [MUL_B_W-1:0] DEPTH_MUL = MUL_B_W'(WINDOW_DEPTH);
    localparam logic [PTR_W-1:0]   LAST_POS  = PTR_W'(WINDOW_DEPTH - 1);

    ctrl_t ctl;
    logic  accept_in;
    logic  out_free;

    step_t                   step_reg, step_next;
    logic [IV_W-1:0]         max_iv_reg, max_iv_next;
    logic [WEIGHT_W-1:0]     weight_reg, weight_next;
    logic [IV_W-1:0]         init_iv_reg, init_iv_next;
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic [TS_W-1:0]         ts_reg, ts_next;
    logic                    pause_in_reg, pause_in_next;
    logic [TS_W-1:0]         start_time_reg, start_time_next;
    logic [TS_W-1:0]         frame_time_reg, frame_time_next;
    logic                    paused_reg, paused_next;
    logic [IV_W-1:0]         last_iv_reg, last_iv_next;
    logic [AVG_W-1:0]        avg_reg, avg_next;
    logic [PTR_W-1:0]        pos_reg, pos_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [TS_W-1:0]         frames_reg, frames_next;
    logic [IV_W-1:0]         fill_reg, fill_next;
    logic [WINDOW_DEPTH-1:0] valid_reg, valid_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [PROD_W-1:0]       acc_reg, acc_next;
    logic [IV_W-1:0]         mean_reg, mean_next;
    logic [FPS_W-1:0]        fps_reg, fps_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [TS_W-1:0]    diff;
    logic [IV_W-1:0]    iv_clamp;
    logic [IV_W-1:0]    old_sample;
    logic [PROD_W:0]    ema_total;
    logic [TS_W-1:0]    elapsed;
    logic [IV_W-1:0]    iv_o, sm_o, mean_o;
    logic [FPS_W-1:0]   fps_o;

    logic               ram_we;
    logic [IV_W-1:0]    ram_q;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [IV_W-1:0]    div_den;
    logic               div_busy;
    logic [NUM_W-1:0]   div_q;

    assign ctl       = fis_rom(step_reg);
    assign cfg_ready = 1'b1;
    assign s_tready  = ctl.cond == COND_WAIT_IN;
    assign accept_in = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb
    begin
        case (ctl.cond)
            COND_JUMP:     step_next = ctl.target;
            COND_WAIT_IN:  step_next = accept_in ? ctl.target : step_reg;
            COND_MODE:     step_next = mode_target(mode_reg);
            COND_PAUSED:   step_next = paused_reg ? ctl.target
                                                  : step_t'(step_reg + 4'd1);
            COND_DIV_BUSY: step_next = div_busy ? step_reg : ctl.target;
            COND_WAIT_OUT: step_next = out_free ? ctl.target : step_reg;
            default:       step_next = STEP_IDLE;
        endcase
    end

    always_comb
    begin
        diff       = ts_reg - frame_time_reg;
        iv_clamp   = (diff > {{(TS_W - IV_W){1'b0}}, max_iv_reg}) ? max_iv_reg
                                                                  : diff[IV_W-1:0];
        old_sample = valid_reg[pos_reg] ? ram_q : fill_reg;
        ema_total  = {1'b0, acc_reg} + {1'b0, prod_reg[PROD_W-9:0], 8'b0} + ROUND_HALF;
        elapsed    = frame_time_reg - start_time_reg;
        iv_o       = paused_reg ? '0 : last_iv_reg;
        sm_o       = paused_reg ? '0 : avg_reg[AVG_W-1:8];
        mean_o     = paused_reg ? '0 : mean_reg;
        fps_o      = paused_reg ? '0 : fps_reg;

        max_iv_next  = max_iv_reg;
        weight_next  = weight_reg;
        init_iv_next = init_iv_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_IV:  max_iv_next  = cfg_data;
                CFG_WEIGHT:  weight_next  = cfg_data[WEIGHT_W-1:0];
                CFG_INIT_IV: init_iv_next = cfg_data;
                default:     ;
            endcase
        end

        mode_next       = mode_reg;
        ts_next         = ts_reg;
        pause_in_next   = pause_in_reg;
        start_time_next = start_time_reg;
        frame_time_next = frame_time_reg;
        paused_next     = paused_reg;
        last_iv_next    = last_iv_reg;
        avg_next        = avg_reg;
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        frames_next     = frames_reg;
        fill_next       = fill_reg;
        valid_next      = valid_reg;
        acc_next        = acc_reg;
        mean_next       = mean_reg;
        fps_next        = fps_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        mul_a           = '0;
        mul_b           = '0;
        ram_we          = 1'b0;
        div_start       = 1'b0;
        div_num         = FPS_NUM;
        div_den         = mean_reg;

        case (ctl.op)
            OP_ACCEPT:
            begin
                if (accept_in)
                begin
                    mode_next     = s_tuser;
                    ts_next       = s_tdata[TS_W-1:0];
                    pause_in_next = s_tdata[TS_W];
                end
            end
            OP_START:
            begin
                start_time_next = ts_reg;
                frame_time_next = ts_reg;
                fill_next       = init_iv_reg;
                valid_next      = '0;
                mul_a           = MUL_A_W'(init_iv_reg);
                mul_b           = DEPTH_MUL;
            end
            OP_SUM_FILL:
            begin
                sum_next = prod_reg[SUM_W-1:0];
            end
            OP_PAUSE:
            begin
                paused_next = pause_in_reg;
            end
            OP_INTERVAL:
            begin
                if (paused_reg)
                begin
                    last_iv_next = '0;
                end
                else
                begin
                    last_iv_next    = iv_clamp;
                    frame_time_next = ts_reg;
                end
                mul_a = avg_reg;
                mul_b = WEIGHT_ONE - MUL_B_W'(weight_reg);
            end
            OP_RING:
            begin
                acc_next            = prod_reg;
                sum_next            = sum_reg - SUM_W'(old_sample) + SUM_W'(last_iv_reg);
                ram_we              = 1'b1;
                valid_next[pos_reg] = 1'b1;
                pos_next            = (pos_reg == LAST_POS) ? '0 : pos_reg + PTR_W'(1);
                frames_next         = frames_reg + TS_W'(1);
                mul_a               = MUL_A_W'(last_iv_reg);
                mul_b               = MUL_B_W'(weight_reg);
            end
            OP_AVERAGE:
            begin
                avg_next = ema_total[AVG_W+7:8];
            end
            OP_MEAN:
            begin
                mean_next = sum_reg[SUM_W-1:PTR_W];
            end
            OP_DIV_FPS:
            begin
                div_start = 1'b1;
                div_num   = FPS_NUM;
                div_den   = mean_reg;
            end
            OP_SET_FPS:
            begin
                if (mean_reg == '0)
                begin
                    fps_next = '0;
                end
                else if (div_q > NUM_W'(FPS_MAX))
                begin
                    fps_next = FPS_MAX;
                end
                else
                begin
                    fps_next = div_q[FPS_W-1:0];
                end
            end
            OP_OUTPUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{OUT_PAD_W{1'b0}}, paused_reg, elapsed, frames_reg,
                                      fps_o, mean_o, sm_o, iv_o};
                end
            end
            default: ;
        endcase

        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_IDLE;
            max_iv_reg     <= RST_MAX_IV;
            weight_reg     <= RST_WEIGHT;
            init_iv_reg    <= RST_INIT_IV;
            start_time_reg <= '0;
            frame_time_reg <= '0;
            paused_reg     <= 1'b0;
            last_iv_reg    <= '0;
            avg_reg        <= '0;
            pos_reg        <= '0;
            sum_reg        <= RESET_SUM;
            frames_reg     <= '0;
            fill_reg       <= RST_INIT_IV;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            max_iv_reg     <= max_iv_next;
            weight_reg     <= weight_next;
            init_iv_reg    <= init_iv_next;
            start_time_reg <= start_time_next;
            frame_time_reg <= frame_time_next;
            paused_reg     <= paused_next;
            last_iv_reg    <= last_iv_next;
            avg_reg        <= avg_next;
            pos_reg        <= pos_next;
            sum_reg        <= sum_next;
            frames_reg     <= frames_next;
            fill_reg       <= fill_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        ts_reg       <= ts_next;
        pause_in_reg <= pause_in_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        mean_reg     <= mean_next;
        fps_reg      <= fps_next;
        out_data_reg <= out_data_next;
    end

    fis_ram #(
        .DATA_W (IV_W),
        .DEPTH  (WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (last_iv_reg),
        .raddr (pos_reg),
        .rdata (ram_q)
    );

    fis_div #(
        .NUM_W (NUM_W),
        .DEN_W (IV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .busy     (div_busy),
        .quotient (div_q)
    );

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("Divider started while a division is in progress.");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> step_reg == STEP_DISPATCH)
        else $error("Input transfer not followed by the dispatch step.");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(step_reg) == STEP_OUTPUT)
        else $error("Result raised outside the output step.");

    a_ring_unpaused: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.op == OP_RING |-> !paused_reg)
        else $error("Ring updated while paused.");

    a_depth_pow2: assert property (@(posedge clk)
        WINDOW_DEPTH == (1 << PTR_W))
        else $error("Window depth is not a power of two.");

endmodule

@@ sv/fis_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module fis_ram #(
    parameter int DATA_W = 20,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/fis_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned bit-serial divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fis_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = trial >= {1'b0, den_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = num;
            den_next = den;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame interval statistics testbench
// Sends timestamped start, frame and pause events with random idling on both
// streams and rewrites the registers between phases. A behavioural model of
// the statistics predicts every result transfer, and each one is compared
// field by field, in order, with what the block returns.
// ----------------------------------------------------------------------------
module tb;
    import fis_pkg::*;

    localparam int WINDOW      = DEF_WINDOW_DEPTH;
    localparam int POS_W       = $clog2(WINDOW);
    localparam int SUM_W       = IV_W + POS_W;
    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX  = 10;
    localparam int TAIL_CYCLES = 100;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [TS_W-1:0]   TS_MAX      = {TS_W{1'b1}};
    localparam logic [IV_W-1:0]   IV_MAX      = {IV_W{1'b1}};

    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic                 paused;
        logic [TS_W-1:0]      elapsed;
        logic [TS_W-1:0]      count;
        logic [FPS_W-1:0]     fps;
        logic [IV_W-1:0]      mean;
        logic [IV_W-1:0]      smoothed;
        logic [IV_W-1:0]      interval;
    } stats_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [IV_W-1:0]        cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [MODE_W-1:0]      s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [IV_W-1:0]     max_iv_reg   = RST_MAX_IV;
    logic [WEIGHT_W-1:0] weight_reg   = RST_WEIGHT;
    logic [IV_W-1:0]     init_iv_reg  = RST_INIT_IV;

    logic [TS_W-1:0]     start_time   = '0;
    logic [TS_W-1:0]     frame_time   = '0;
    logic                paused_flag  = 1'b0;
    logic [IV_W-1:0]     last_iv      = '0;
    logic [AVG_W-1:0]    avg_q8       = '0;
    logic [IV_W-1:0]     ring_samples [WINDOW] = '{default: RST_INIT_IV};
    logic [POS_W-1:0]    ring_pos     = '0;
    logic [SUM_W-1:0]    window_sum   = SUM_W'(WINDOW * RST_INIT_IV);
    logic [TS_W-1:0]     frames_done  = '0;

    stats_t          pending_stats [$];
    stats_t          want_stats;
    stats_t          got_stats;
    logic [TS_W-1:0] last_ts       = '0;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    int              quiet_cycles  = 0;
    int              mismatches    = 0;
    int              events_sent   = 0;
    int              frames_sent   = 0;
    int              results_seen  = 0;
    int              reg_writes    = 0;

    frame_interval_statistics_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic stats_t advance_statistics(input logic [MODE_W-1:0] mode,
                                                  input logic [TS_W-1:0]   ts,
                                                  input logic              pv);
        logic [TS_W-1:0] gap;
        logic [IV_W-1:0] iv;
        logic [63:0]     acc;
        logic [63:0]     mean;
        logic [63:0]     rate;
        stats_t          r;
        int              i;
        case (mode)
            MODE_START:
            begin
                start_time = ts;
                frame_time = ts;
                for (i = 0; i < WINDOW; i++)
                    ring_samples[i] = init_iv_reg;
                window_sum = SUM_W'(WINDOW * init_iv_reg);
            end
            MODE_FRAME:
            begin
                if (paused_flag)
                    last_iv = '0;
                else
                begin
                    gap        = ts - frame_time;
                    frame_time = ts;
                    iv         = (gap > TS_W'(max_iv_reg)) ? max_iv_reg : gap[IV_W-1:0];
                    last_iv    = iv;
                    acc = 64'(avg_q8) * (64'd256 - 64'(weight_reg))
                        + (64'(iv) << 8) * 64'(weight_reg) + 64'd128;
                    avg_q8     = acc[8 +: AVG_W];
                    window_sum = window_sum - ring_samples[ring_pos] + iv;
                    ring_samples[ring_pos] = iv;
                    if (ring_pos == POS_W'(WINDOW - 1))
                        ring_pos = '0;
                    else
                        ring_pos = ring_pos + 1'b1;
                    frames_done = frames_done + 1'b1;
                end
            end
            MODE_PAUSE:
                paused_flag = pv;
            default:
                ;
        endcase
        mean = 64'(window_sum) / WINDOW;
        rate = 64'd0;
        if (mean != 64'd0)
        begin
            rate = 64'(FPS_NUM) / mean;
            if (rate > 64'(FPS_MAX))
                rate = 64'(FPS_MAX);
        end
        r = '0;
        if (!paused_flag)
        begin
            r.interval = last_iv;
            r.smoothed = avg_q8[8 +: IV_W];
            r.mean     = mean[IV_W-1:0];
            r.fps      = rate[FPS_W-1:0];
        end
        r.count   = frames_done;
        r.elapsed = frame_time - start_time;
        r.paused  = paused_flag;
        return r;
    endfunction

    function automatic logic [TS_W-1:0] random_ts();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TS_W-1:0];
    endfunction

    function automatic logic [TS_W-1:0] next_interval();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return TS_W'($urandom_range(40));
        else if (r < 75)
            return TS_W'($urandom_range(70000, 1000));
        else if (r < 95)
            return TS_W'($urandom_range(1200000, 70000));
        return random_ts();
    endfunction

    function automatic logic [IV_W-1:0] pick_value(input logic [IV_W-1:0] lo,
                                                   input logic [IV_W-1:0] hi);
        case ($urandom_range(9))
            0: return lo;
            1: return hi;
            default: return IV_W'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic check_field(input string name, input logic [TS_W-1:0] want_v,
                               input logic [TS_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: %s expected %0d, got %0d", $realtime, name, want_v, got_v);
        end
    endtask

    task automatic send_event(input logic [MODE_W-1:0] mode, input logic [TS_W-1:0] ts,
                              input logic pv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(IN_TDATA_W - TS_W - 1){1'b0}}, pv, ts};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_stats.push_back(advance_statistics(mode, ts, pv));
        events_sent++;
        if (mode == MODE_FRAME)
            frames_sent++;
        if (mode == MODE_START || mode == MODE_FRAME)
            last_ts = ts;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_stats.size() != 0);
    endtask

    task automatic set_registers(input logic [IV_W-1:0] max_v, input logic [IV_W-1:0] weight_v,
                                 input logic [IV_W-1:0] init_v);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [IV_W-1:0]      val [3];
        int                   i;
        idx = '{CFG_MAX_IV, CFG_WEIGHT, CFG_INIT_IV};
        val = '{max_v, weight_v, init_v};
        wait_for_results();
        for (i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx[i])
                CFG_MAX_IV:  max_iv_reg  = val[i];
                CFG_WEIGHT:  weight_reg  = val[i][WEIGHT_W-1:0];
                CFG_INIT_IV: init_iv_reg = val[i];
                default:     ;
            endcase
            reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_unused_mode();
        send_event(MODE_UNUSED, TS_MAX, 1'b1);
    endtask

    task automatic test_frame_intervals();
        send_event(MODE_FRAME, 48'd1000, 1'b0);
        send_event(MODE_FRAME, 48'd1000, 1'b1);
        send_event(MODE_FRAME, TS_MAX, 1'b0);
        send_event(MODE_FRAME, 48'd5, 1'b0);
    endtask

    task automatic test_pause_flag();
        send_event(MODE_PAUSE, 48'd0, 1'b1);
        send_event(MODE_FRAME, 48'd9000, 1'b0);
        send_event(MODE_PAUSE, TS_MAX, 1'b0);
        send_event(MODE_FRAME, 48'd12000, 1'b0);
    endtask

    task automatic test_start_event();
        send_event(MODE_START, TS_MAX - 48'd10, 1'b0);
        send_event(MODE_FRAME, 48'd20, 1'b0);
    endtask

    task automatic test_register_extremes();
        set_registers('0, '0, '0);
        send_event(MODE_START, 48'd0, 1'b0);
        send_event(MODE_FRAME, 48'd50000, 1'b0);
        set_registers(IV_MAX, 20'd255, IV_MAX);
        send_event(MODE_START, 48'd1, 1'b0);
        send_event(MODE_FRAME, TS_MAX, 1'b0);
        set_registers(20'd1, 20'd1, 20'd1);
        send_event(MODE_START, 48'd100, 1'b0);
        send_event(MODE_FRAME, 48'd200, 1'b0);
        set_registers(RST_MAX_IV, 20'(RST_WEIGHT), 20'd15);
        send_event(MODE_START, 48'd300, 1'b0);
        set_registers(RST_MAX_IV, 20'(RST_WEIGHT), 20'd16);
        send_event(MODE_START, 48'd400, 1'b1);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int chunks, input int per_chunk);
        int c;
        int k;
        int r;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (c = 0; c < chunks; c++)
        begin
            set_registers(pick_value(20'd1, IV_MAX), pick_value(20'd1, 20'd255),
                          pick_value('0, IV_MAX));
            for (k = 0; k < per_chunk; k++)
            begin
                if (k == per_chunk / 2)
                    wait_for_results();
                r = $urandom_range(99);
                if (k == 0 || r < 4)
                    send_event(MODE_START, (r < 2) ? random_ts() : last_ts + next_interval(),
                               1'($urandom));
                else if (paused_flag && r < 40)
                    send_event(MODE_PAUSE, random_ts(), 1'b0);
                else if (r < 7)
                    send_event(MODE_PAUSE, random_ts(), 1'b1);
                else if (r < 9)
                    send_event(MODE_W'($urandom), random_ts(), 1'($urandom));
                else
                    send_event(MODE_FRAME, last_ts + next_interval(), 1'($urandom));
            end
        end
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            got_stats = m_tdata;
            if (pending_stats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result transfer with nothing expected", $realtime);
            end
            else
            begin
                want_stats = pending_stats.pop_front();
                check_field("interval_us", want_stats.interval, got_stats.interval);
                check_field("smoothed_interval_us", want_stats.smoothed, got_stats.smoothed);
                check_field("window_mean_us", want_stats.mean, got_stats.mean);
                check_field("frames_per_second_q8", want_stats.fps, got_stats.fps);
                check_field("frame_count", want_stats.count, got_stats.count);
                check_field("elapsed_us", want_stats.elapsed, got_stats.elapsed);
                check_field("is_paused", want_stats.paused, got_stats.paused);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout after %0d cycles without a transfer.", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        send_idle_pct = 25;
        recv_idle_pct = 52;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        test_unused_mode();
        test_frame_intervals();
        test_pause_flag();
        test_start_event();
        test_register_extremes();
        test_random_traffic(25, 52, 3, 108);
        test_random_traffic(52, 25, 3, 108);
        test_random_traffic(0, 0, 3, 108);
        wait_for_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        $display("Sent %0d events, %0d of them frames, with %0d register writes.",
                 events_sent, frames_sent, reg_writes);
        $display("Compared %0d results and found %0d field mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
